FILE: rtl/core/srfr_pkg.sv
// Shared types, constants and the CRC8 update for the serial frame receiver.
// No dependencies; used by srfr_cfg_regs, the top level and the testbench.
`default_nettype none

package srfr_pkg;

  localparam int FRAME_LEN_DEF = 6;

  localparam logic [15:0] BYTE_TIMEOUT_RST = 16'd100;
  localparam logic [15:0] LINK_TIMEOUT_RST = 16'd10000;

  localparam logic [7:0] CRC_POLY       = 8'h47;
  localparam logic [7:0] SEQ_RESET      = 8'd5;
  localparam logic [7:0] SEQ_WAIT_LIMIT = 8'd35;

  localparam logic [7:0] START_LO   = 8'hFA;
  localparam logic [7:0] START_HI   = 8'hFD;
  localparam logic [7:0] TYPE_LAST  = 8'hFA;
  localparam logic [7:0] TYPE_CMD   = 8'hFB;
  localparam logic [7:0] TYPE_REJ   = 8'hFC;
  localparam logic [7:0] TYPE_EXT   = 8'hFD;
  localparam logic [7:0] CMD_END    = 8'h22;
  localparam logic [7:0] EXT_END    = 8'h1F;

  localparam logic REG_BYTE_TIMEOUT = 1'b0;
  localparam logic REG_LINK_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_OPEN  = 2'd3
  } func_t;

  typedef enum logic {
    KIND_FRAME   = 1'b0,
    KIND_TIMEOUT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [15:0] byte_timeout;
    logic [15:0] link_timeout;
  } srfr_cfg_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = c ^ CRC_POLY;
      end
      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/srfr_cfg_regs.sv
// APB-style register file for the two timeout registers.
// Depends on srfr_pkg for the register struct and reset values.
`default_nettype none

module srfr_cfg_regs import srfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output srfr_cfg_t        cfg
);

  srfr_cfg_t cfg_r, cfg_nxt;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[2])
        REG_BYTE_TIMEOUT: cfg_nxt.byte_timeout = pwdata[15:0];
        REG_LINK_TIMEOUT: cfg_nxt.link_timeout = pwdata[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.byte_timeout <= BYTE_TIMEOUT_RST;
      cfg_r.link_timeout <= LINK_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BYTE_TIMEOUT: prdata = {16'd0, cfg_r.byte_timeout};
      REG_LINK_TIMEOUT: prdata = {16'd0, cfg_r.link_timeout};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/core/serial_frame_receiver_crc8_seq.sv
// Top level of the serial frame receiver: input register, frame/sequence/CRC
// logic, result register. Depends on srfr_pkg and srfr_cfg_regs.
//
// Each input item (a received byte, an idle tick, a clear or an open command)
// is captured in an input register and fully processed once the result
// register is free; any result is then registered in the result register and
// held on the output until it is taken. The block
// takes one item per cycle; in_tready falls only while the input register holds
// an item and a result waits on a stalled out_tready.
// A good frame gives one result with its first five bytes; a link timeout gives
// a result with kind 1 and all other fields zero. Byte and link timeouts count
// idle ticks and fire on equality with the configured values.
`default_nettype none

module serial_frame_receiver_crc8_seq import srfr_pkg::*; #(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] rx_byte
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // in_tuser: [1:0] func
  input  wire logic [1:0]  in_tuser,
  // out_tdata: [7:0] pkt_byte0, [15:8] pkt_byte1, [23:16] pkt_byte2,
  //            [31:24] pkt_byte3, [39:32] pkt_byte4, [40] session_fault
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,
  // out_tuser: [0] kind
  output logic [0:0]       out_tuser,
  // out_tlast: end_of_session
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int BUF_N = FRAME_LEN - 1;
  localparam int CNT_W = $clog2(FRAME_LEN + 1);
  localparam int IDX_W = $clog2(BUF_N);

  srfr_cfg_t cfg;

  srfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  func_t      s1_func_r;
  logic [7:0] s1_byte_r;
  logic       accept, fire;

  // receiver state
  logic [7:0]       buf_r [BUF_N];
  logic [7:0]       buf_nxt [BUF_N];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       exp_r, exp_nxt;
  logic [7:0]       rsy_r, rsy_nxt;
  logic             bw_r, bw_nxt;
  logic             fw_r, fw_nxt;
  logic [15:0]      bt_r, bt_nxt;
  logic [15:0]      ft_r, ft_nxt;
  logic             cf_r, cf_nxt;
  logic             ls_r, ls_nxt;
  logic             lo_r, lo_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic [39:0] out_bytes_r, out_bytes_nxt;
  logic        out_end_r, out_end_nxt;
  logic        out_fault_r, out_fault_nxt;

  logic        res_valid;
  logic [39:0] pkt_w;
  logic        is_end;
  logic        is_start;

  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  for (genvar k = 0; k < 5; k++) begin : g_pkt
    if (k < BUF_N) begin : g_have
      assign pkt_w[8*k +: 8] = buf_r[k];
    end else begin : g_none
      assign pkt_w[8*k +: 8] = 8'd0;
    end
  end

  assign is_end = (buf_r[0] == TYPE_CMD && buf_r[1] == CMD_END) ||
                  (buf_r[0] == TYPE_EXT && buf_r[1] == EXT_END) ||
                  buf_r[0] == TYPE_LAST || buf_r[0] == TYPE_REJ;
  assign is_start = s1_byte_r >= START_LO && s1_byte_r <= START_HI;

  always_comb begin
    buf_nxt      = buf_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    exp_nxt      = exp_r;
    rsy_nxt      = rsy_r;
    bw_nxt       = bw_r;
    fw_nxt       = fw_r;
    bt_nxt       = bt_r;
    ft_nxt       = ft_r;
    cf_nxt       = cf_r;
    ls_nxt       = ls_r;
    lo_nxt       = lo_r;
    res_valid    = 1'b0;
    out_kind_nxt = KIND_FRAME;
    out_bytes_nxt = 40'd0;
    out_end_nxt  = 1'b0;
    out_fault_nxt = 1'b0;
    if (fire) begin
      case (s1_func_r)
        FUNC_BYTE: begin
          if (lo_r) begin
            // continuation byte
            if (bw_nxt && cnt_nxt >= CNT_W'(2)) begin
              if (cnt_nxt < CNT_W'(BUF_N)) begin
                buf_nxt[cnt_nxt[IDX_W-1:0]] = s1_byte_r;
                crc_nxt = crc8_update(crc_nxt, s1_byte_r);
              end
              if (cnt_nxt < CNT_W'(FRAME_LEN)) begin
                cnt_nxt = cnt_nxt + CNT_W'(1);
              end
              bt_nxt = 16'd0;
            end
            // sequence byte
            if (cnt_nxt == CNT_W'(1)) begin
              buf_nxt[1] = s1_byte_r;
              crc_nxt = crc8_update(crc_nxt, s1_byte_r);
              cnt_nxt = CNT_W'(2);
              bt_nxt  = 16'd0;
              if (s1_byte_r == exp_nxt) begin
                ls_nxt = 1'b0;
              end else if (s1_byte_r == rsy_nxt) begin
                ls_nxt  = 1'b0;
                exp_nxt = rsy_nxt;
              end else begin
                cnt_nxt = '0;
                ls_nxt  = 1'b1;
                fw_nxt  = 1'b1;
              end
            end
            // start byte
            if (is_start && cnt_nxt == '0) begin
              buf_nxt[0] = s1_byte_r;
              crc_nxt = crc8_update(8'd0, s1_byte_r);
              cnt_nxt = CNT_W'(1);
              bt_nxt  = 16'd0;
              bw_nxt  = 1'b1;
            end
            // frame complete
            if (cnt_nxt == CNT_W'(FRAME_LEN)) begin
              if (exp_nxt < SEQ_WAIT_LIMIT) begin
                fw_nxt = 1'b1;
              end
              cnt_nxt = '0;
              exp_nxt = exp_nxt + 8'd1;
              bw_nxt  = 1'b0;
              bt_nxt  = 16'd0;
              ft_nxt  = 16'd0;
              if (s1_byte_r != crc_nxt) begin
                cf_nxt = 1'b1;
              end else begin
                rsy_nxt = rsy_nxt + 8'd1;
                if (is_end) begin
                  fw_nxt = 1'b0;
                end
                res_valid     = 1'b1;
                out_kind_nxt  = KIND_FRAME;
                out_bytes_nxt = pkt_w;
                out_end_nxt   = is_end;
                out_fault_nxt = is_end && (cf_nxt || ls_nxt);
              end
            end
          end
        end
        FUNC_TICK: begin
          if (lo_r) begin
            if (fw_nxt) begin
              ft_nxt = ft_nxt + 16'd1;
            end
            if (bw_nxt) begin
              bt_nxt = bt_nxt + 16'd1;
            end
            if (ft_nxt == cfg.link_timeout) begin
              cnt_nxt      = '0;
              bw_nxt       = 1'b0;
              fw_nxt       = 1'b0;
              ft_nxt       = 16'd0;
              lo_nxt       = 1'b0;
              res_valid    = 1'b1;
              out_kind_nxt = KIND_TIMEOUT;
            end
            if (bt_nxt == cfg.byte_timeout) begin
              cnt_nxt = '0;
              bw_nxt  = 1'b0;
              bt_nxt  = 16'd0;
            end
          end
        end
        FUNC_CLEAR: begin
          cf_nxt  = 1'b0;
          exp_nxt = SEQ_RESET;
          rsy_nxt = SEQ_RESET;
          bw_nxt  = 1'b0;
          ls_nxt  = 1'b0;
          fw_nxt  = 1'b0;
          bt_nxt  = 16'd0;
          ft_nxt  = 16'd0;
        end
        FUNC_OPEN: begin
          cnt_nxt = '0;
          bw_nxt  = 1'b0;
          fw_nxt  = 1'b0;
          bt_nxt  = 16'd0;
          ft_nxt  = 16'd0;
          lo_nxt  = 1'b1;
        end
        default: begin
          lo_nxt = lo_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      crc_r       <= 8'd0;
      exp_r       <= SEQ_RESET;
      rsy_r       <= SEQ_RESET;
      bw_r        <= 1'b0;
      fw_r        <= 1'b0;
      bt_r        <= 16'd0;
      ft_r        <= 16'd0;
      cf_r        <= 1'b0;
      ls_r        <= 1'b0;
      lo_r        <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      exp_r       <= exp_nxt;
      rsy_r       <= rsy_nxt;
      bw_r        <= bw_nxt;
      fw_r        <= fw_nxt;
      bt_r        <= bt_nxt;
      ft_r        <= ft_nxt;
      cf_r        <= cf_nxt;
      ls_r        <= ls_nxt;
      lo_r        <= lo_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r <= func_t'(in_tuser);
      s1_byte_r <= in_tdata;
    end
    if (fire) begin
      out_kind_r  <= out_kind_nxt;
      out_bytes_r <= out_bytes_nxt;
      out_end_r   <= out_end_nxt;
      out_fault_r <= out_fault_nxt;
    end
    buf_r <= buf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_fault_r, out_bytes_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_end_r;

endmodule

`default_nettype wire

FILE: rtl/core/srfr_checker.sv
// Port-level assertions for the serial frame receiver, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module srfr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [0:0]  out_tuser,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("stalled result item changed");

  a_timeout_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 48'd0 && !out_tlast)
    else $error("link timeout item carries frame fields");

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[7:0] >= 8'hFA && out_tdata[7:0] <= 8'hFD)
    else $error("frame item without start byte");

  a_fault_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[40] |-> out_tlast)
    else $error("session fault outside end of session");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled while result side is free");

endmodule

bind serial_frame_receiver_crc8_seq srfr_checker u_srfr_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_serial_frame_receiver_crc8_seq.sv
// Testbench for serial_frame_receiver_crc8_seq: drives bytes, ticks and link
// commands, predicts delivered frames and link timeouts, checks the results.
// Depends on srfr_pkg and the receiver RTL.
module tb_serial_frame_receiver_crc8_seq;
  import srfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic            kind;
    logic [4:0][7:0] pkt;
    logic            eos;
    logic            fault;
  } frame_result_t;

  class frame_scoreboard;
    logic [15:0]   byte_limit, link_limit;
    logic [7:0]    frame_bytes [5];
    logic [2:0]    fill;
    logic [7:0]    crc, exp_seq, resync_seq, last_rx;
    logic          byte_wait, frame_wait, crc_fault, lost, link_up;
    logic [15:0]   byte_ticks, frame_ticks;
    frame_result_t frames_due[$];
    int            errors;

    function new();
      byte_limit = BYTE_TIMEOUT_RST;
      link_limit = LINK_TIMEOUT_RST;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      fill = 0;
      crc = 8'h00;
      last_rx = 8'h00;
      link_up = 1'b0;
      errors = 0;
      clear_session();
    endfunction

    static function logic [7:0] crc8_step(logic [7:0] crc_in, logic [7:0] b);
      logic [7:0] c;
      c = crc_in ^ b;
      repeat (8) c = c[7] ? ((c ^ CRC_POLY) << 1) : (c << 1);
      return c;
    endfunction

    function void set_limit(logic idx, logic [15:0] value);
      if (idx == REG_BYTE_TIMEOUT) byte_limit = value;
      else link_limit = value;
    endfunction

    function void clear_session();
      crc_fault = 1'b0;
      lost = 1'b0;
      exp_seq = SEQ_RESET;
      resync_seq = SEQ_RESET;
      byte_wait = 1'b0;
      frame_wait = 1'b0;
      byte_ticks = 16'd0;
      frame_ticks = 16'd0;
    endfunction

    function void queue_result(frame_result_t r);
      frames_due = {frames_due, r};
    endfunction

    function void push_rx(logic [7:0] b);
      if (fill == 0) crc = 8'h00;
      if (fill < FRAME_LEN_DEF - 1) begin
        frame_bytes[fill] = b;
        crc = crc8_step(crc, b);
      end
      last_rx = b;
      if (fill < FRAME_LEN_DEF) fill++;
    endfunction

    function void on_tick();
      frame_result_t r;
      if (frame_wait) frame_ticks++;
      if (byte_wait) byte_ticks++;
      if (frame_ticks == link_limit) begin
        fill = 0;
        byte_wait = 1'b0;
        frame_wait = 1'b0;
        frame_ticks = 16'd0;
        link_up = 1'b0;
        r = '0;
        r.kind = KIND_TIMEOUT;
        queue_result(r);
      end
      if (byte_ticks == byte_limit) begin
        fill = 0;
        byte_wait = 1'b0;
        byte_ticks = 16'd0;
      end
    endfunction

    function void on_byte(logic [7:0] c);
      frame_result_t r;
      logic          eos;
      if (byte_wait && fill >= 2) begin
        push_rx(c);
        byte_ticks = 16'd0;
      end
      if (fill == 1) begin
        push_rx(c);
        byte_ticks = 16'd0;
        if (c == exp_seq) begin
          lost = 1'b0;
        end else if (c == resync_seq) begin
          lost = 1'b0;
          exp_seq = resync_seq;
        end else begin
          fill = 0;
          lost = 1'b1;
          frame_wait = 1'b1;
        end
      end
      if (c >= START_LO && c <= START_HI && fill == 0) begin
        push_rx(c);
        byte_ticks = 16'd0;
        byte_wait = 1'b1;
      end
      if (fill != FRAME_LEN_DEF) return;
      if (exp_seq < SEQ_WAIT_LIMIT) frame_wait = 1'b1;
      fill = 0;
      exp_seq++;
      byte_wait = 1'b0;
      byte_ticks = 16'd0;
      frame_ticks = 16'd0;
      if (last_rx != crc) begin
        crc_fault = 1'b1;
        return;
      end
      resync_seq++;
      eos = (frame_bytes[0] == TYPE_CMD && frame_bytes[1] == CMD_END) ||
            (frame_bytes[0] == TYPE_EXT && frame_bytes[1] == EXT_END) ||
            frame_bytes[0] == TYPE_LAST || frame_bytes[0] == TYPE_REJ;
      if (eos) frame_wait = 1'b0;
      r.kind = KIND_FRAME;
      for (int k = 0; k < 5; k++) r.pkt[k] = frame_bytes[k];
      r.eos = eos;
      r.fault = eos && (crc_fault || lost);
      queue_result(r);
    endfunction

    function void accept_event(func_t f, logic [7:0] b);
      case (f)
        FUNC_BYTE: if (link_up) on_byte(b);
        FUNC_TICK: if (link_up) on_tick();
        FUNC_CLEAR: clear_session();
        default: begin
          fill = 0;
          byte_wait = 1'b0;
          frame_wait = 1'b0;
          byte_ticks = 16'd0;
          frame_ticks = 16'd0;
          link_up = 1'b1;
        end
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_output(logic kind, logic [39:0] pkt, logic eos, logic fault);
      frame_result_t want;
      if (frames_due.size() == 0) begin
        report($sformatf("unexpected result kind=%0d bytes=%h eos=%0d fault=%0d",
                         kind, pkt, eos, fault));
        return;
      end
      want = frames_due.pop_front();
      if (kind !== want.kind || pkt !== want.pkt || eos !== want.eos ||
          fault !== want.fault)
        report($sformatf({"expected kind=%0d bytes=%h eos=%0d fault=%0d, ",
                          "got kind=%0d bytes=%h eos=%0d fault=%0d"},
                         want.kind, want.pkt, want.eos, want.fault,
                         kind, pkt, eos, fault));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [1:0]  in_tuser = 2'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  frame_scoreboard sb = new();
  int tx_idle_pct = 26;
  int rx_idle_pct = 55;
  int items_done = 0;
  int stall_cycles = 0;

  serial_frame_receiver_crc8_seq uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_output(out_tuser[0], out_tdata[39:0], out_tlast, out_tdata[40]);
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // leaves in_tvalid high after the accepting edge
  task automatic send_item(func_t f, logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    if (sb.link_up || f == FUNC_CLEAR || f == FUNC_OPEN) items_done++;
    sb.accept_event(f, b);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(FUNC_TICK, 8'($urandom));
  endtask

  task automatic send_frame(logic [7:0] start, logic [7:0] seq, logic [23:0] payload,
                            bit bad_crc, int upto, bit tick_gaps);
    logic [7:0] fb [6];
    logic [7:0] c;
    fb[0] = start;
    fb[1] = seq;
    fb[2] = payload[7:0];
    fb[3] = payload[15:8];
    fb[4] = payload[23:16];
    c = 8'h00;
    for (int i = 0; i < 5; i++) c = frame_scoreboard::crc8_step(c, fb[i]);
    fb[5] = bad_crc ? c ^ 8'($urandom_range(1, 255)) : c;
    for (int i = 0; i < upto; i++) begin
      if (tick_gaps && i > 0 && $urandom_range(11) == 0) send_ticks($urandom_range(1, 3));
      send_item(FUNC_BYTE, fb[i]);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(logic idx, logic [15:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.set_limit(idx, value);
  endtask

  function automatic logic [7:0] any_start();
    return START_LO + 8'($urandom_range(3));
  endfunction

  task automatic run_segment(int n);
    int target;
    int r;
    target = items_done + n;
    while (items_done < target) begin
      r = $urandom_range(99);
      if (!sb.link_up) begin
        if (r < 80) send_item(FUNC_OPEN, 8'($urandom));
        else send_item(r[0] ? FUNC_BYTE : FUNC_TICK, 8'($urandom));
      end else if (r < 55) begin
        send_frame(any_start(), sb.exp_seq, 24'($urandom), 1'b0, 6, 1'b1);
      end else if (r < 61) begin
        send_frame(any_start(), sb.resync_seq, 24'($urandom), 1'b0, 6, 1'b1);
      end else if (r < 66) begin
        send_frame(any_start(), 8'($urandom), 24'($urandom), 1'b0, 6, 1'b0);
      end else if (r < 71) begin
        send_frame(any_start(), sb.exp_seq, 24'($urandom), 1'b1, 6, 1'b1);
      end else if (r < 77) begin
        send_frame(any_start(), sb.exp_seq, 24'($urandom), 1'b0,
                   $urandom_range(1, 5), 1'b0);
        if (r[0]) send_ticks($urandom_range(1, 20));
      end else if (r < 87) begin
        send_ticks(($urandom_range(9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 24));
      end else if (r < 90) begin
        send_item(FUNC_CLEAR, 8'($urandom));
      end else if (r < 92) begin
        send_item(FUNC_OPEN, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_item(FUNC_BYTE, 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [15:0] bt, lt;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // link closed: ignored
    send_item(FUNC_BYTE, TYPE_LAST);
    send_item(FUNC_TICK, 8'h00);
    send_item(FUNC_OPEN, 8'h00);
    send_frame(TYPE_CMD, sb.exp_seq, 24'hFFFFFF, 1'b0, 6, 1'b0);
    send_frame(TYPE_EXT, sb.exp_seq, 24'h000000, 1'b1, 6, 1'b0);
    // sequence byte that is a start byte restarts the frame, then resync
    send_item(FUNC_BYTE, TYPE_REJ);
    send_frame(TYPE_REJ, sb.resync_seq, 24'h5AA5C3, 1'b0, 6, 1'b0);
    send_item(FUNC_CLEAR, 8'hFF);
    send_item(FUNC_TICK, 8'hFF);

    for (int s = 0; s < 6; s++) begin
      wait_drained();
      case (s)
        0: begin bt = 16'd3; lt = 16'd6; end
        1: begin bt = 16'd1; lt = 16'd1; end
        2: begin bt = 16'hFFFF; lt = 16'hFFFF; end
        3: begin bt = 16'd12; lt = 16'd40; end
        4: begin bt = 16'($urandom_range(2, 20)); lt = 16'($urandom_range(2, 60)); end
        default: begin bt = BYTE_TIMEOUT_RST; lt = 16'($urandom_range(1, 30)); end
      endcase
      write_timeout(REG_BYTE_TIMEOUT, bt);
      write_timeout(REG_LINK_TIMEOUT, lt);
      case (s % 3)
        0: begin tx_idle_pct = 26; rx_idle_pct = 55; end
        1: begin tx_idle_pct = 55; rx_idle_pct = 26; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      run_segment(310);
    end

    wait_drained();
    if (sb.errors == 0 && sb.frames_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
